// ----- rtl/core/bbt_pkg.sv -----
package bbt_pkg;

    // datapath widths
    localparam int unsigned DIV_W      = 64;  // dividend / quotient
    localparam int unsigned DIVISOR_W  = 24;  // sample_rate * 60 fits here
    localparam int unsigned MUL_A_W    = 64;  // multiplicand / product
    localparam int unsigned MUL_B_W    = 22;  // ticks in one bar
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 18;

    localparam int unsigned BPB_W = 6;
    localparam int unsigned TPB_W = 16;
    localparam int unsigned BPM_W = 10;
    localparam int unsigned SR_W  = 18;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BEATS_PER_BAR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BEAT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEATS_PER_MINUTE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE      = 2'd3;

    // register reset values
    localparam logic [BPB_W-1:0] BPB_RST = 6'd4;
    localparam logic [TPB_W-1:0] TPB_RST = 16'd1920;
    localparam logic [BPM_W-1:0] BPM_RST = 10'd120;
    localparam logic [SR_W-1:0]  SR_RST  = 18'd48000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_RATE,
        S_MUL_RES,
        S_DIV_TICK,
        S_DIV_BEAT,
        S_DIV_BAR,
        S_MUL_BAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        reposition;
        logic [31:0] frame_number;
        logic [15:0] period_frames;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] bar_out;
        logic [5:0]  beat_out;
        logic [15:0] tick_out;
        logic [47:0] bar_start_out;
    } t_out_beat;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_W-1:0]     quotient;
        logic [DIVISOR_W-1:0] remainder;
    } t_div_rsp;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [MUL_A_W-1:0] product;
    } t_mul_rsp;

endpackage

// ----- rtl/core/bbt_stream_if.sv -----
interface bbt_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/bar_beat_tick_transport_counter_top.sv -----
// Each input beat runs three shift-add multiplies and two or three passes of
//   the 2-bit-per-cycle divider before its result beat is registered.
// The next input beat is taken only after the previous result is loaded into
//   the output register, and also while that finished result still waits there.
// Reset (synchronous, active low): registers to 4/1920/120/48000, position
//   bar 0 beat 1 tick 0, input held not ready; first beat resyncs from frame.
module bar_beat_tick_transport_counter_top #(
    parameter int unsigned BAR_WIDTH      = 32,
    parameter int unsigned BAR_TICK_WIDTH = 48
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [bbt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bbt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    bbt_stream_if.sink                         i_in,
    bbt_stream_if.source                       o_res
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [bbt_pkg::BPB_W-1:0] r_bpb;
    logic [bbt_pkg::TPB_W-1:0] r_tpb;
    logic [bbt_pkg::BPM_W-1:0] r_bpm;
    logic [bbt_pkg::SR_W-1:0]  r_sr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpb <= bbt_pkg::BPB_RST;
            r_tpb <= bbt_pkg::TPB_RST;
            r_bpm <= bbt_pkg::BPM_RST;
            r_sr  <= bbt_pkg::SR_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                bbt_pkg::CFG_BEATS_PER_BAR:    r_bpb <= i_cfg_wdata[bbt_pkg::BPB_W-1:0];
                bbt_pkg::CFG_TICKS_PER_BEAT:   r_tpb <= i_cfg_wdata[bbt_pkg::TPB_W-1:0];
                bbt_pkg::CFG_BEATS_PER_MINUTE: r_bpm <= i_cfg_wdata[bbt_pkg::BPM_W-1:0];
                bbt_pkg::CFG_SAMPLE_RATE:      r_sr  <= i_cfg_wdata[bbt_pkg::SR_W-1:0];
            endcase
        end
    end

    // A zero bar length, beat resolution or sample rate acts as one.
    logic [bbt_pkg::BPB_W-1:0]     bpb_e;
    logic [bbt_pkg::TPB_W-1:0]     tpb_e;
    logic [bbt_pkg::SR_W-1:0]      sr_e;
    logic [bbt_pkg::DIVISOR_W-1:0] denom;
    logic [bbt_pkg::MUL_B_W-1:0]   ticks_per_bar;

    assign bpb_e = (r_bpb == '0) ? bbt_pkg::BPB_W'(1) : r_bpb;
    assign tpb_e = (r_tpb == '0) ? bbt_pkg::TPB_W'(1) : r_tpb;
    assign sr_e  = (r_sr == '0) ? bbt_pkg::SR_W'(1) : r_sr;
    // frames per minute: x60 = x64 - x4
    assign denom = {sr_e, 6'b0} - bbt_pkg::DIVISOR_W'({sr_e, 2'b0});
    assign ticks_per_bar = bbt_pkg::MUL_B_W'(bpb_e) * bbt_pkg::MUL_B_W'(tpb_e);

    // ---------------------------------------------------------------
    // shared arithmetic units
    // ---------------------------------------------------------------
    bbt_pkg::t_mul_req mul_req;
    bbt_pkg::t_mul_rsp mul_rsp;
    bbt_pkg::t_div_req div_req;
    bbt_pkg::t_div_rsp div_rsp;

    bbt_mul_serial u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    bbt_div_serial u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------------------------------------------------------
    // transport state and sequencer
    // ---------------------------------------------------------------
    bbt_pkg::t_state           r_state, n_state;
    logic                      r_resync, n_resync;     // first beat after reset
    logic                      r_sync, n_sync;         // this beat recomputes
    logic [BAR_WIDTH-1:0]      r_bar_count, n_bar_count;
    logic [5:0]                r_beat, n_beat;
    logic [15:0]               r_tick, n_tick;
    logic [BAR_TICK_WIDTH-1:0] r_bar_start, n_bar_start;
    logic [63:0]               r_work, n_work;         // abs beat, or bar wraps
    logic                      r_wrap0, n_wrap0;       // wrapped a stale beat
    logic                      r_out_valid, n_out_valid;
    bbt_pkg::t_out_beat        r_out, n_out;

    // advance path helpers
    logic [63:0] total_w;
    logic [63:0] nbeats_w;
    logic        wrap0_w;
    logic [5:0]  beat_base_w;
    logic [63:0] pos_w;
    logic [63:0] wraps_w;
    logic [63:0] bar_base_w;
    logic [63:0] bar_ext;
    logic [63:0] bar_start_ext;

    assign total_w  = 64'(r_tick) + div_rsp.quotient;
    assign nbeats_w = div_rsp.quotient;
    // beat held above a shrunken bar length: first increment opens a new bar
    assign wrap0_w     = (r_beat > bpb_e) || (r_beat == '0);
    assign beat_base_w = wrap0_w ? 6'd1 : r_beat;
    assign pos_w       = 64'(beat_base_w - 6'd1) + (wrap0_w ? (nbeats_w - 64'd1) : nbeats_w);
    assign wraps_w     = div_rsp.quotient + 64'(r_wrap0);
    // first beat of the bar = absolute beat - beat within the bar
    assign bar_base_w  = r_work - 64'(div_rsp.remainder[5:0]);

    assign bar_ext       = 64'(r_bar_count);
    assign bar_start_ext = 64'(r_bar_start);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbt_pkg::S_IDLE;
            r_resync    <= 1'b1;
            r_bar_count <= '0;
            r_beat      <= 6'd1;
            r_tick      <= '0;
            r_bar_start <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_resync    <= n_resync;
            r_bar_count <= n_bar_count;
            r_beat      <= n_beat;
            r_tick      <= n_tick;
            r_bar_start <= n_bar_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sync  <= n_sync;
        r_work  <= n_work;
        r_wrap0 <= n_wrap0;
        r_out   <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_resync    = r_resync;
        n_sync      = r_sync;
        n_bar_count = r_bar_count;
        n_beat      = r_beat;
        n_tick      = r_tick;
        n_bar_start = r_bar_start;
        n_work      = r_work;
        n_wrap0     = r_wrap0;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        mul_req     = '0;
        div_req     = '0;

        unique case (r_state)
            bbt_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_sync        = i_in.payload.reposition || r_resync;
                    mul_req.start = 1'b1;
                    mul_req.a     = n_sync ? 64'(i_in.payload.frame_number)
                                           : 64'(i_in.payload.period_frames);
                    mul_req.b     = bbt_pkg::MUL_B_W'(r_bpm);
                    n_state       = bbt_pkg::S_MUL_RATE;
                end
            end
            bbt_pkg::S_MUL_RATE: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mul_rsp.product;
                    mul_req.b     = bbt_pkg::MUL_B_W'(tpb_e);
                    n_state       = bbt_pkg::S_MUL_RES;
                end
            end
            bbt_pkg::S_MUL_RES: begin
                if (mul_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_rsp.product;
                    div_req.divisor  = denom;
                    n_state          = bbt_pkg::S_DIV_TICK;
                end
            end
            bbt_pkg::S_DIV_TICK: begin
                // quotient: absolute tick on resync, tick advance otherwise
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_sync ? div_rsp.quotient : total_w;
                    div_req.divisor  = bbt_pkg::DIVISOR_W'(tpb_e);
                    n_state          = bbt_pkg::S_DIV_BEAT;
                end
            end
            bbt_pkg::S_DIV_BEAT: begin
                if (div_rsp.done) begin
                    n_tick = div_rsp.remainder[15:0];
                    if (r_sync) begin
                        n_work           = div_rsp.quotient;
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                        div_req.divisor  = bbt_pkg::DIVISOR_W'(bpb_e);
                        n_state          = bbt_pkg::S_DIV_BAR;
                    end else if (nbeats_w == '0) begin
                        // no beat carry: zero wraps through the bar step
                        n_work        = '0;
                        mul_req.start = 1'b1;
                        mul_req.a     = '0;
                        mul_req.b     = ticks_per_bar;
                        n_state       = bbt_pkg::S_MUL_BAR;
                    end else begin
                        n_wrap0          = wrap0_w;
                        div_req.start    = 1'b1;
                        div_req.dividend = pos_w;
                        div_req.divisor  = bbt_pkg::DIVISOR_W'(bpb_e);
                        n_state          = bbt_pkg::S_DIV_BAR;
                    end
                end
            end
            bbt_pkg::S_DIV_BAR: begin
                if (div_rsp.done) begin
                    n_beat        = div_rsp.remainder[5:0] + 6'd1;
                    mul_req.start = 1'b1;
                    if (r_sync) begin
                        n_bar_count = BAR_WIDTH'(div_rsp.quotient + 64'd1);
                        mul_req.a   = bar_base_w;
                        mul_req.b   = bbt_pkg::MUL_B_W'(tpb_e);
                    end else begin
                        n_work    = wraps_w;
                        mul_req.a = wraps_w;
                        mul_req.b = ticks_per_bar;
                    end
                    n_state = bbt_pkg::S_MUL_BAR;
                end
            end
            bbt_pkg::S_MUL_BAR: begin
                if (mul_rsp.done) begin
                    if (r_sync) begin
                        n_bar_start = BAR_TICK_WIDTH'(mul_rsp.product);
                    end else begin
                        n_bar_start = r_bar_start + BAR_TICK_WIDTH'(mul_rsp.product);
                        n_bar_count = r_bar_count + BAR_WIDTH'(r_work);
                    end
                    n_resync = 1'b0;
                    n_state  = bbt_pkg::S_DONE;
                end
            end
            bbt_pkg::S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid         = 1'b1;
                    n_out.bar_out       = bar_ext[31:0];
                    n_out.beat_out      = r_beat;
                    n_out.tick_out      = r_tick;
                    n_out.bar_start_out = bar_start_ext[47:0];
                    n_state             = bbt_pkg::S_IDLE;
                end
            end
        endcase
    end

    // not ready while reset is held
    assign i_in.ready    = (r_state == bbt_pkg::S_IDLE) && i_rst_n;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_beat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.payload.beat_out != '0))
        else $error("result beat_out is zero");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_rsp.busy && div_rsp.busy))
        else $error("multiplier and divider busy together");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == bbt_pkg::S_DIV_TICK || r_state == bbt_pkg::S_DIV_BEAT
                          || r_state == bbt_pkg::S_DIV_BAR))
        else $error("divider finished outside a divide step");

    a_resync_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbt_pkg::S_DONE) |-> !r_resync)
        else $error("resync still pending after a completed beat");

endmodule

// ----- rtl/core/bbt_mul_serial.sv -----
// Shift-add multiplier, one multiplier bit per cycle, product modulo 2^64.
// Stops as soon as the remaining multiplier bits are all zero.
module bbt_mul_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bbt_pkg::t_mul_req i_req,
    output bbt_pkg::t_mul_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [bbt_pkg::MUL_A_W-1:0] r_a;
    logic [bbt_pkg::MUL_B_W-1:0] r_b;
    logic [bbt_pkg::MUL_A_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_b == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[bbt_pkg::MUL_A_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[bbt_pkg::MUL_B_W-1:1]};
        end
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

// ----- rtl/core/bbt_div_serial.sv -----
// Restoring divider, two quotient bits per cycle (two chained
// compare/subtract steps on a 25-bit partial remainder).
module bbt_div_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bbt_pkg::t_div_req i_req,
    output bbt_pkg::t_div_rsp o_rsp
);

    localparam int unsigned ITER  = bbt_pkg::DIV_W / 2;
    localparam int unsigned CNT_W = $clog2(ITER);
    localparam int unsigned RW    = bbt_pkg::DIVISOR_W;

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [bbt_pkg::DIV_W-1:0] r_q;
    logic [RW-1:0]             r_rem;
    logic [RW-1:0]             r_div;

    logic [RW:0]   s1, s2, t1, t2, d_ext;
    logic          ge1, ge2;

    always_comb begin
        d_ext = {1'b0, r_div};
        s1    = {r_rem, r_q[bbt_pkg::DIV_W-1]};
        ge1   = (s1 >= d_ext);
        t1    = ge1 ? (s1 - d_ext) : s1;
        s2    = {t1[RW-1:0], r_q[bbt_pkg::DIV_W-2]};
        ge2   = (s2 >= d_ext);
        t2    = ge2 ? (s2 - d_ext) : s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[bbt_pkg::DIV_W-3:0], ge1, ge2};
            r_rem <= t2[RW-1:0];
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

endmodule

// ----- bench/tb_bar_beat_tick_transport_counter_top.sv -----
`timescale 1ns / 100ps

module tb_bar_beat_tick_transport_counter_top;

    // Position state is kept in 64 bits and cut to the block's widths.
    localparam bit [63:0] BAR_MASK      = (64'd1 << 32) - 64'd1;
    localparam bit [63:0] BAR_TICK_MASK = (64'd1 << 48) - 64'd1;

    localparam int       RAND_PHASES     = 13;
    localparam int       BEATS_PER_PHASE = 100;
    localparam int       SETTLE_CYCLES   = 8;    // idle margin before a register write
    localparam int       TAIL_CYCLES     = 200;  // above the worst item latency
    localparam int       HOLD_CYCLES     = 3000; // long receiver hold-off
    localparam int       MAX_REPORTS     = 40;
    localparam realtime  RUN_LIMIT       = 20ms;

    typedef enum int {
        PACE_NONE,
        PACE_TX_IDLE,
        PACE_RX_STALL,
        PACE_BOTH
    } t_pacing;

    // Expected transport positions: a bit-exact copy of the position math, with
    // its own register file, fed at every accepted input beat.
    class transport_position_scoreboard;
        logic [bbt_pkg::BPB_W-1:0] bpb_reg;
        logic [bbt_pkg::TPB_W-1:0] tpb_reg;
        logic [bbt_pkg::BPM_W-1:0] bpm_reg;
        logic [bbt_pkg::SR_W-1:0]  sr_reg;
        bit                        resync_due;
        bit [63:0]                 bar_num;
        bit [63:0]                 beat_num;
        bit [63:0]                 tick_num;
        bit [63:0]                 bar_origin;
        bbt_pkg::t_out_beat        expected_positions[$];
        int                        mismatches;

        function new();
            bpb_reg    = bbt_pkg::BPB_RST;
            tpb_reg    = bbt_pkg::TPB_RST;
            bpm_reg    = bbt_pkg::BPM_RST;
            sr_reg     = bbt_pkg::SR_RST;
            resync_due = 1'b1;
            bar_num    = 64'd0;
            beat_num   = 64'd1;
            tick_num   = 64'd0;
            bar_origin = 64'd0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [bbt_pkg::CFG_IDX_W-1:0] idx,
                                logic [bbt_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bbt_pkg::CFG_BEATS_PER_BAR:    bpb_reg = data[bbt_pkg::BPB_W-1:0];
                bbt_pkg::CFG_TICKS_PER_BEAT:   tpb_reg = data[bbt_pkg::TPB_W-1:0];
                bbt_pkg::CFG_BEATS_PER_MINUTE: bpm_reg = data[bbt_pkg::BPM_W-1:0];
                bbt_pkg::CFG_SAMPLE_RATE:      sr_reg  = data[bbt_pkg::SR_W-1:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_positions.size();
        endfunction

        // Resync from the frame or advance by one period, then queue the position.
        function void note_input(bbt_pkg::t_in_beat b);
            bit [63:0] bpb, tpb, bpm, denom, frame, frames;
            bit [63:0] tick_pos, beat_pos, bar, total, nbeats, wraps, first, pos;
            bbt_pkg::t_out_beat want;
            bpb    = (bpb_reg == '0) ? 64'd1 : 64'(bpb_reg);
            tpb    = (tpb_reg == '0) ? 64'd1 : 64'(tpb_reg);
            bpm    = 64'(bpm_reg);
            denom  = ((sr_reg == '0) ? 64'd1 : 64'(sr_reg)) * 64'd60;
            frame  = 64'(b.frame_number);
            frames = 64'(b.period_frames);
            if (b.reposition || resync_due) begin
                tick_pos   = frame * bpm * tpb / denom;
                beat_pos   = tick_pos / tpb;
                bar        = beat_pos / bpb;
                beat_num   = beat_pos - bar * bpb + 64'd1;
                tick_num   = tick_pos - beat_pos * tpb;
                bar_origin = (bar * bpb * tpb) & BAR_TICK_MASK;
                bar_num    = (bar + 64'd1) & BAR_MASK;
                resync_due = 1'b0;
            end else begin
                total    = tick_num + frames * tpb * bpm / denom;
                nbeats   = total / tpb;
                tick_num = total % tpb;
                wraps    = 64'd0;
                if (nbeats != 64'd0) begin
                    first = beat_num;
                    // beat held above a shrunken bar: first step opens a new bar
                    if (first > bpb || first == 64'd0) begin
                        wraps  = 64'd1;
                        first  = 64'd1;
                        nbeats = nbeats - 64'd1;
                    end
                    pos      = first - 64'd1 + nbeats;
                    wraps    = wraps + pos / bpb;
                    beat_num = pos % bpb + 64'd1;
                end
                bar_num    = (bar_num + wraps) & BAR_MASK;
                bar_origin = (bar_origin + wraps * bpb * tpb) & BAR_TICK_MASK;
            end
            want.bar_out       = bar_num[31:0];
            want.beat_out      = beat_num[5:0];
            want.tick_out      = tick_num[15:0];
            want.bar_start_out = bar_origin[47:0];
            expected_positions.push_back(want);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: mismatch: %s", $time, what);
        endtask

        task check_result(bbt_pkg::t_out_beat got);
            bbt_pkg::t_out_beat want;
            if (expected_positions.size() == 0) begin
                report_mismatch($sformatf("unexpected result bar %0d beat %0d tick %0d",
                                          got.bar_out, got.beat_out, got.tick_out));
                return;
            end
            want = expected_positions.pop_front();
            if (got.bar_out !== want.bar_out)
                report_mismatch($sformatf("bar_out %0d, want %0d", got.bar_out, want.bar_out));
            if (got.beat_out !== want.beat_out)
                report_mismatch($sformatf("beat_out %0d, want %0d", got.beat_out, want.beat_out));
            if (got.tick_out !== want.tick_out)
                report_mismatch($sformatf("tick_out %0d, want %0d", got.tick_out, want.tick_out));
            if (got.bar_start_out !== want.bar_start_out)
                report_mismatch($sformatf("bar_start_out %0d, want %0d",
                                          got.bar_start_out, want.bar_start_out));
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic [bbt_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bbt_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    bbt_stream_if #(.T(bbt_pkg::t_in_beat))  period_in ();
    bbt_stream_if #(.T(bbt_pkg::t_out_beat)) position_out ();

    transport_position_scoreboard sb;

    int          tx_idle_pct;   // main process only
    int          rx_stall_pct;  // written by NBA, read by the receiver
    logic        rx_hold;       // long hold-off, owned by hold_receiver
    logic [31:0] frame_cursor;

    bar_beat_tick_transport_counter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (period_in),
        .o_res       (position_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT);
        $display("tb_bar_beat_tick_transport_counter_top: done, errors");
        $finish;
    end

    // Receiver: checks every result beat taken at an edge, then picks the
    // next ready value. Inputs are sampled before the edge's updates land.
    initial begin
        position_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && position_out.valid && position_out.ready)
                sb.check_result(position_out.payload);
            position_out.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic set_pacing(input t_pacing mode);
        tx_idle_pct   = (mode == PACE_TX_IDLE) ? 47 : (mode == PACE_BOTH) ? 33 : 0;
        rx_stall_pct <= (mode == PACE_RX_STALL) ? 47 : (mode == PACE_BOTH) ? 33 : 0;
    endtask

    // Offer one period beat, with a random gap first, and hold it until taken.
    task automatic send_beat(input bbt_pkg::t_in_beat b);
        int gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            period_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        period_in.valid   <= 1'b1;
        period_in.payload <= b;
        do @(posedge i_clk); while (!period_in.ready);
        sb.note_input(b);
    endtask

    // Stop offering and wait for every expected position to come back.
    task automatic drain();
        period_in.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic hold_receiver(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    task automatic write_reg(input logic [bbt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bbt_pkg::CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Random bits above a register's width; the block must drop them.
    function automatic logic [bbt_pkg::CFG_DATA_W-1:0] with_junk(
            input logic [bbt_pkg::CFG_DATA_W-1:0] v, input int w, input bit junk);
        logic [bbt_pkg::CFG_DATA_W-1:0] upper;
        upper = bbt_pkg::CFG_DATA_W'($urandom());
        upper = upper << w;
        return junk ? (v | upper) : v;
    endfunction

    // Registers only change with the block drained.
    task automatic apply_settings(input int bpb, input int tpb, input int bpm, input int sr,
                                  input bit junk);
        drain();
        write_reg(bbt_pkg::CFG_BEATS_PER_BAR,
                  with_junk(bbt_pkg::CFG_DATA_W'(bpb), bbt_pkg::BPB_W, junk));
        write_reg(bbt_pkg::CFG_TICKS_PER_BEAT,
                  with_junk(bbt_pkg::CFG_DATA_W'(tpb), bbt_pkg::TPB_W, junk));
        write_reg(bbt_pkg::CFG_BEATS_PER_MINUTE,
                  with_junk(bbt_pkg::CFG_DATA_W'(bpm), bbt_pkg::BPM_W, junk));
        write_reg(bbt_pkg::CFG_SAMPLE_RATE, bbt_pkg::CFG_DATA_W'(sr));
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic bbt_pkg::t_in_beat make_beat(input bit repos, input logic [31:0] frame,
                                                    input logic [15:0] frames);
        bbt_pkg::t_in_beat b;
        b.reposition    = repos;
        b.frame_number  = frame;
        b.period_frames = frames;
        return b;
    endfunction

    // Mostly a running transport: contiguous periods of typical size, with
    // occasional jumps to a random frame and odd period lengths.
    function automatic bbt_pkg::t_in_beat random_beat();
        bbt_pkg::t_in_beat b;
        int                kind;
        logic [15:0]       frames;
        kind = $urandom_range(9);
        if (kind < 6)
            frames = 16'($urandom_range(2048, 64));
        else if (kind < 8)
            frames = 16'($urandom_range(65535, 0));
        else if (kind == 8)
            frames = 16'd0;
        else
            frames = 16'hFFFF;
        b.reposition = ($urandom_range(99) < 8);
        if (b.reposition && $urandom_range(1) == 1)
            frame_cursor = $urandom();
        b.frame_number  = frame_cursor;
        b.period_frames = frames;
        frame_cursor    = frame_cursor + 32'(frames);
        return b;
    endfunction

    initial begin
        int bpb, tpb, bpm, sr;
        bit junk;

        sb                = new();
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_wdata       = '0;
        period_in.valid   = 1'b0;
        period_in.payload = '0;
        rx_hold           = 1'b0;
        rx_stall_pct      = 0;
        tx_idle_pct       = 0;
        frame_cursor      = 32'd0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, reset registers (120 bpm, 4/4, 1920 ticks, 48 kHz) ---
        // first beat after reset resyncs even without the reposition flag
        send_beat(make_beat(1'b0, 32'd1_234_567, 16'd512));
        send_beat(make_beat(1'b0, 32'd0, 16'd0));          // empty period: no advance
        send_beat(make_beat(1'b0, 32'd0, 16'hFFFF));       // longest period
        send_beat(make_beat(1'b1, 32'd0, 16'd0));          // back to bar 1 beat 1
        send_beat(make_beat(1'b1, 32'hFFFF_FFFF, 16'hFFFF));
        repeat (3) send_beat(make_beat(1'b0, 32'd0, 16'd1024));
        // a bar lasts 96000 frames here: land just short of it and carry over
        send_beat(make_beat(1'b1, 32'd95_990, 16'd0));
        send_beat(make_beat(1'b0, 32'd0, 16'd256));

        // nominal top of bar, tick and tempo registers, sample rate 1: bar start tick wraps
        apply_settings(32, 65535, 1023, 1, 1'b0);
        send_beat(make_beat(1'b1, 32'hFFFF_FFFF, 16'd0));
        send_beat(make_beat(1'b0, 32'd0, 16'hFFFF));
        send_beat(make_beat(1'b0, 32'd0, 16'd1));

        // bar length beyond the nominal range, one tick per beat
        apply_settings(63, 1, 1023, 262143, 1'b1);
        send_beat(make_beat(1'b1, 32'hDEAD_BEEF, 16'd0));
        send_beat(make_beat(1'b0, 32'd0, 16'hFFFF));

        // all registers zero: zero tempo never moves, others act as one
        apply_settings(0, 0, 0, 0, 1'b0);
        send_beat(make_beat(1'b1, 32'hA5A5_5A5A, 16'd0));
        send_beat(make_beat(1'b0, 32'd0, 16'hFFFF));

        // zero bar, tick and rate registers with a real tempo
        apply_settings(0, 0, 1023, 0, 1'b0);
        send_beat(make_beat(1'b1, 32'h0001_0000, 16'd0));
        send_beat(make_beat(1'b0, 32'd0, 16'd100));

        // park on beat 30 with a high tick, then shrink bar and beat: the held
        // tick carries and the held beat wraps to a new bar on the next step
        apply_settings(32, 65535, 60, 48000, 1'b0);
        send_beat(make_beat(1'b1, 32'd1_436_000, 16'd0));
        apply_settings(4, 1000, 60, 48000, 1'b0);
        send_beat(make_beat(1'b0, 32'd0, 16'd0));
        send_beat(make_beat(1'b0, 32'd0, 16'd100));

        // --- random phases, each with its own registers and pacing ---
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            junk = (ph % 3 == 2);
            case (ph)
                0: begin bpb = 4;  tpb = 1920;  bpm = 120;  sr = 48000;  end
                1: begin bpb = 1;  tpb = 1;     bpm = 1;    sr = 1;      end
                2: begin bpb = 32; tpb = 65535; bpm = 1023; sr = 262143; end
                3: begin bpb = 3;  tpb = 960;   bpm = 97;   sr = 44100;  end
                4: begin bpb = 7;  tpb = 480;   bpm = 180;  sr = 96000;  end
                5: begin bpb = 63; tpb = 65535; bpm = 1023; sr = 1;      end
                6: begin bpb = 1;  tpb = 1;     bpm = 1023; sr = 1;      end
                default: begin
                    bpb = ($urandom_range(7) == 0) ? $urandom_range(63, 0)
                                                   : $urandom_range(32, 1);
                    tpb = $urandom_range(65535, 1);
                    bpm = $urandom_range(1023, 1);
                    sr  = ($urandom_range(1) == 1) ? $urandom_range(262143, 1)
                                                   : $urandom_range(200000, 8000);
                end
            endcase
            apply_settings(bpb, tpb, bpm, sr, junk);
            set_pacing(t_pacing'(ph % 4));
            // receiver goes quiet while beats keep coming: input must back up
            if (ph == 2)
                fork
                    hold_receiver(HOLD_CYCLES);
                join_none
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // mid-phase, sender stops until every position is back
                if (ph == 5 && n == BEATS_PER_PHASE / 2)
                    drain();
                send_beat(random_beat());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.outstanding() != 0)
            sb.report_mismatch($sformatf("%0d positions never came out", sb.outstanding()));

        if (sb.mismatches == 0)
            $display("tb_bar_beat_tick_transport_counter_top: done, clean");
        else
            $display("tb_bar_beat_tick_transport_counter_top: done, errors");
        $finish;
    end

endmodule
